// ===== hdl/recd_pkg.sv =====
// Shared types, constants and the direction grid for the remote event code decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package recd_pkg;

    // Configuration port
    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned DATA_W      = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_BIT_MASK    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PLAIN_REMOTE_USAGE = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIAL_REMOTE_USAGE  = 8'd2;

    // Register reset values
    localparam logic [DATA_W-1:0] RESET_REPEAT_BIT_MASK    = 32'h0000_8000;
    localparam logic [DATA_W-1:0] RESET_PLAIN_REMOTE_USAGE = 32'h0001_0046;
    localparam logic [DATA_W-1:0] RESET_DIAL_REMOTE_USAGE  = 32'hFFA1_0003;

    // Special dial button values
    localparam logic [DATA_W-1:0] DIAL_TOUCH_VALUE   = 32'h0000_0040;
    localparam logic [DATA_W-1:0] DIAL_RELEASE_VALUE = 32'hFFFF_FFAA;
    localparam logic [DATA_W-1:0] DIAL_IGNORE_VALUE  = 32'hFFFF_FFFF;
    localparam logic [7:0]        DIAL_UNIQUE_BIT    = 8'h80;
    localparam logic [3:0]        GRID_MAX           = 4'd8;

    // Dial capture phase
    typedef enum logic [1:0] {
        PHASE_IDLE   = 2'd0,
        PHASE_X      = 2'd1,
        PHASE_Y      = 2'd2
    } dial_phase_t;

    // 9x9 direction grid, indexed by X and Y magnitude (both 0..8)
    function automatic logic [4:0] dir_grid(input logic [3:0] xm, input logic [3:0] ym);
        logic [4:0] row [0:8];
        case (xm)
            4'd0: row = '{5'h00,5'h15,5'h15,5'h16,5'h16,5'h16,5'h16,5'h17,5'h17};
            4'd1: row = '{5'h05,5'h0d,5'h11,5'h12,5'h12,5'h12,5'h16,5'h17,5'h17};
            4'd2: row = '{5'h05,5'h09,5'h0e,5'h12,5'h12,5'h12,5'h13,5'h13,5'h13};
            4'd3: row = '{5'h06,5'h0a,5'h0a,5'h0e,5'h0e,5'h12,5'h13,5'h13,5'h13};
            4'd4: row = '{5'h06,5'h0a,5'h0a,5'h0e,5'h0e,5'h0f,5'h13,5'h13,5'h13};
            4'd5: row = '{5'h06,5'h0a,5'h0a,5'h0a,5'h0f,5'h0f,5'h0f,5'h0f,5'h13};
            4'd6: row = '{5'h06,5'h06,5'h0b,5'h0b,5'h0b,5'h0f,5'h0f,5'h0f,5'h0f};
            4'd7: row = '{5'h07,5'h07,5'h0b,5'h0b,5'h0b,5'h0f,5'h0f,5'h0f,5'h0f};
            4'd8: row = '{5'h07,5'h07,5'h0b,5'h0b,5'h0b,5'h0b,5'h0f,5'h0f,5'h0f};
            default: row = '{default: 5'h00};
        endcase
        if (ym > GRID_MAX) begin
            return 5'h00;
        end
        return row[ym];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/remote_event_code_decoder.sv =====
// Remote event code decoder: turns HID (usage, value) requests into remote key codes.
// Each request passes through an input register and then a result register.
// Throughput: one request per cycle; a request stalls only while the result register
// holds an untaken result and m_ready is low.
// Reset: aresetn synchronous active low; clears valids, capture state, repeat state and
// last button, and loads the configuration registers with their defaults. Uses recd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module remote_event_code_decoder
    import recd_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // configuration write port
    input  wire logic                   cfg_wen,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [DATA_W-1:0]      cfg_wdata,
    // event requests
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [DATA_W-1:0]      s_usage_code,
    input  wire logic [DATA_W-1:0]      s_event_value,
    // key code results
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [DATA_W-1:0]           m_prefix_code,
    output logic [DATA_W-1:0]           m_key_code,
    output logic                        m_is_repeat
);

    // Configuration registers
    logic [DATA_W-1:0] repeat_mask_reg;
    logic [DATA_W-1:0] plain_usage_reg;
    logic [DATA_W-1:0] dial_usage_reg;

    // Input register
    logic              in_valid_reg;
    logic [DATA_W-1:0] in_usage_reg;
    logic [DATA_W-1:0] in_value_reg;

    // Decoder state
    dial_phase_t       phase_reg, phase_next;
    logic [7:0]        saved_x_reg, saved_x_next;
    logic [DATA_W-1:0] last_button_reg, last_button_next;
    logic              repeat_reg, repeat_next;

    // Result register
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_prefix_reg, out_prefix_next;
    logic [DATA_W-1:0] out_key_reg, out_key_next;
    logic              out_repeat_reg, out_repeat_next;

    logic proc_fire;
    logic emit;
    logic [3:0] xm, ym;
    logic [7:0] dial_key;

    // Handshakes
    assign proc_fire = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || proc_fire;

    assign m_valid       = out_valid_reg;
    assign m_prefix_code = out_prefix_reg;
    assign m_key_code    = out_key_reg;
    assign m_is_repeat   = out_repeat_reg;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            repeat_mask_reg <= RESET_REPEAT_BIT_MASK;
            plain_usage_reg <= RESET_PLAIN_REMOTE_USAGE;
            dial_usage_reg  <= RESET_DIAL_REMOTE_USAGE;
        end else if (cfg_wen) begin
            case (cfg_index)
                CFG_REPEAT_BIT_MASK:    repeat_mask_reg <= cfg_wdata;
                CFG_PLAIN_REMOTE_USAGE: plain_usage_reg <= cfg_wdata;
                CFG_DIAL_REMOTE_USAGE:  dial_usage_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_usage_reg <= s_usage_code;
            in_value_reg <= s_event_value;
        end
    end

    // Dial key assembly: grid code, X direction, Y direction and the unique bit
    assign xm = saved_x_reg[3:0];
    assign ym = in_value_reg[3:0];
    assign dial_key = {3'b000, dir_grid(xm, ym)}
                    | {1'b0, saved_x_reg[7:4], 3'b000}
                    | {2'b00, in_value_reg[7:4], 2'b00}
                    | DIAL_UNIQUE_BIT;

    // Event decode
    always_comb begin
        phase_next       = phase_reg;
        saved_x_next     = saved_x_reg;
        last_button_next = last_button_reg;
        repeat_next      = repeat_reg;
        emit             = 1'b0;
        out_prefix_next  = out_prefix_reg;
        out_key_next     = out_key_reg;
        out_repeat_next  = out_repeat_reg;

        if (proc_fire) begin
            if (in_usage_reg == plain_usage_reg) begin
                // plain remote wins over everything, even mid-capture
                repeat_next     = |(in_value_reg & repeat_mask_reg);
                emit            = 1'b1;
                out_prefix_next = in_usage_reg;
                out_key_next    = in_value_reg & ~repeat_mask_reg;
                out_repeat_next = repeat_next;
            end else begin
                case (phase_reg)
                    PHASE_Y: begin
                        saved_x_next = {4'h0, saved_x_reg[3:0]};
                        // out-of-range magnitude: no result, stay in Y capture
                        if (xm <= GRID_MAX && ym <= GRID_MAX) begin
                            phase_next      = PHASE_IDLE;
                            emit            = 1'b1;
                            out_prefix_next = dial_usage_reg;
                            out_key_next    = {24'h0, dial_key};
                            out_repeat_next = repeat_reg;
                        end
                    end
                    PHASE_X: begin
                        saved_x_next = in_value_reg[7:0];
                        phase_next   = PHASE_Y;
                    end
                    default: begin
                        if (in_usage_reg == dial_usage_reg) begin
                            if (in_value_reg == DIAL_RELEASE_VALUE) begin
                                repeat_next      = 1'b0;
                                last_button_next = '0;
                            end else if (in_value_reg != DIAL_IGNORE_VALUE) begin
                                if (last_button_reg == in_value_reg) begin
                                    repeat_next = 1'b1;
                                end
                                last_button_next = in_value_reg;
                                if (in_value_reg == DIAL_TOUCH_VALUE) begin
                                    phase_next = PHASE_X;
                                end else begin
                                    emit            = 1'b1;
                                    out_prefix_next = in_usage_reg;
                                    out_key_next    = in_value_reg;
                                    out_repeat_next = repeat_next;
                                end
                            end
                        end
                    end
                endcase
            end
        end

        // result register valid: new result loads, taken result drains
        out_valid_next = out_valid_reg && !m_ready;
        if (emit) begin
            out_valid_next = 1'b1;
        end
    end

    // State and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PHASE_IDLE;
            saved_x_reg     <= '0;
            last_button_reg <= '0;
            repeat_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            saved_x_reg     <= saved_x_next;
            last_button_reg <= last_button_next;
            repeat_reg      <= repeat_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_prefix_reg <= out_prefix_next;
        out_key_reg    <= out_key_next;
        out_repeat_reg <= out_repeat_next;
    end

endmodule

`default_nettype wire
